// ===== rtl/core/xed_pkg.sv =====
// xed_pkg: constants, reference tables and shared types for the xml entity decoder
// depends on nothing; imported by every module of the block
package xed_pkg;

	localparam int CHAR_BITS_DEF = 16;
	localparam int NUM_REFS      = 7;
	localparam int HOLD_DEPTH    = 4;
	localparam int NAME_LEN      = 5;
	localparam int MAX_RES       = 6;
	localparam int COUNT_BITS    = $clog2(MAX_RES + 1);
	localparam int HOLD_BITS     = $clog2(HOLD_DEPTH + 1);
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [7:0] AMP_CODE = 8'h26;

	localparam logic [2:0] REF_LEN [NUM_REFS] = '{3'd3, 3'd3, 3'd4, 3'd5, 3'd5, 3'd4, 3'd4};

	localparam logic [7:0] REF_NAME [NUM_REFS][NAME_LEN] = '{
		'{8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B},
		'{8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
		'{8'h23, 8'h31, 8'h30, 8'h3B, 8'h00},
		'{8'h23, 8'h31, 8'h33, 8'h3B, 8'h00}
	};

	localparam logic [7:0] REF_VALUE [NUM_REFS] = '{
		8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h0A, 8'h0D
	};

	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		logic                  fin;
	} job_ctl_t;

	typedef struct packed {
		logic                 pending;
		logic [HOLD_BITS-1:0] held_cnt;
		logic                 push;
	} front_stat_t;

endpackage

// ===== rtl/core/xed_chan_if.sv =====
// xed_chan_if: valid/ready channel interfaces for input characters and decoded results
// depends on nothing; used by xed_front, xed_back and xml_entity_decoder
interface xed_in_if #(
	parameter int CHAR_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] ch;
	logic                 is_final;

	modport source (output valid, output ch, output is_final, input ready);
	modport sink (input valid, input ch, input is_final, output ready);
endinterface

interface xed_out_if #(
	parameter int CHAR_BITS = 16
);
	logic                 valid;
	logic                 ready;
	logic [CHAR_BITS-1:0] out_ch;
	logic                 run_end;
	logic                 string_end;

	modport source (output valid, output out_ch, output run_end, output string_end,
		input ready);
	modport sink (input valid, input out_ch, input run_end, input string_end,
		output ready);
endinterface

// ===== rtl/core/xed_front.sv =====
// xed_front: accepts characters, tracks the held ampersand match and builds output jobs
// depends on xed_pkg and xed_in_if
module xed_front #(
	parameter int CHAR_BITS = xed_pkg::CHAR_BITS_DEF
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	xed_in_if.sink                                               text,
	input  logic                                                 q_ready,
	output logic                                                 push,
	output xed_pkg::job_ctl_t                                    push_ctl,
	output logic [xed_pkg::MAX_RES-1:0][CHAR_BITS-1:0]           push_chars,
	output xed_pkg::front_stat_t                                 stat
);
	import xed_pkg::*;

	logic                 pending_q;
	logic [HOLD_BITS-1:0] held_cnt_q;
	logic [CHAR_BITS-1:0] held_q [HOLD_DEPTH];

	logic                  accept;
	logic                  full;
	logic                  part;
	logic [CHAR_BITS-1:0]  full_val;
	logic                  is_amp;
	logic                  hold;
	logic                  pending_d;
	logic [HOLD_BITS-1:0]  held_cnt_d;
	logic [COUNT_BITS-1:0] count;
	logic                  pre_ok;
	logic [7:0]            nm;

	assign text.ready = q_ready;
	assign accept     = text.valid && q_ready;
	assign is_amp     = text.ch == CHAR_BITS'(AMP_CODE);

	always_comb begin
		full     = 1'b0;
		part     = 1'b0;
		full_val = '0;
		pre_ok   = 1'b0;
		nm       = '0;
		for (int i = 0; i < NUM_REFS; i++) begin
			pre_ok = REF_LEN[i] > 3'(held_cnt_q);
			for (int k = 0; k < HOLD_DEPTH; k++) begin
				if (HOLD_BITS'(k) < held_cnt_q && held_q[k] != CHAR_BITS'(REF_NAME[i][k]))
					pre_ok = 1'b0;
			end
			nm = REF_NAME[i][held_cnt_q];
			if (pre_ok && text.ch == CHAR_BITS'(nm)) begin
				if (REF_LEN[i] == 3'(held_cnt_q) + 3'd1) begin
					full     = 1'b1;
					full_val = CHAR_BITS'(REF_VALUE[i]);
				end else begin
					part = 1'b1;
				end
			end
		end
	end

	always_comb begin
		pending_d  = pending_q;
		held_cnt_d = held_cnt_q;
		hold       = 1'b0;
		count      = '0;
		push_chars = '0;
		if (pending_q) begin
			if (full) begin
				count         = COUNT_BITS'(1);
				push_chars[0] = full_val;
				pending_d     = 1'b0;
				held_cnt_d    = '0;
			end else if (part && !text.is_final && held_cnt_q < HOLD_BITS'(HOLD_DEPTH)) begin
				hold       = 1'b1;
				held_cnt_d = held_cnt_q + HOLD_BITS'(1);
			end else begin
				push_chars[0] = CHAR_BITS'(AMP_CODE);
				for (int k = 0; k < HOLD_DEPTH; k++)
					push_chars[k+1] = held_q[k];
				held_cnt_d = '0;
				if (is_amp && !text.is_final) begin
					pending_d = 1'b1;
					count     = COUNT_BITS'(held_cnt_q) + COUNT_BITS'(1);
				end else begin
					pending_d = 1'b0;
					count     = COUNT_BITS'(held_cnt_q) + COUNT_BITS'(2);
					for (int j = 1; j < MAX_RES; j++) begin
						if (COUNT_BITS'(j) == COUNT_BITS'(held_cnt_q) + COUNT_BITS'(1))
							push_chars[j] = text.ch;
					end
				end
			end
		end else if (is_amp && !text.is_final) begin
			pending_d  = 1'b1;
			held_cnt_d = '0;
		end else begin
			count         = COUNT_BITS'(1);
			push_chars[0] = text.ch;
		end
	end

	assign push           = accept && count != '0;
	assign push_ctl.count = count;
	assign push_ctl.fin   = text.is_final;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 1'b0;
			held_cnt_q <= '0;
		end else if (accept) begin
			pending_q  <= pending_d;
			held_cnt_q <= held_cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && hold)
			held_q[held_cnt_q[$clog2(HOLD_DEPTH)-1:0]] <= text.ch;
	end

	assign stat.pending  = pending_q;
	assign stat.held_cnt = held_cnt_q;
	assign stat.push     = push;

endmodule

// ===== rtl/core/xed_queue.sv =====
// xed_queue: short job queue between the classifying front and the emitting back
// depends on xed_pkg
module xed_queue #(
	parameter int CHAR_BITS = xed_pkg::CHAR_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       push,
	input  xed_pkg::job_ctl_t                          push_ctl,
	input  logic [xed_pkg::MAX_RES-1:0][CHAR_BITS-1:0] push_chars,
	output logic                                       q_ready,
	output logic                                       q_valid,
	input  logic                                       pop,
	output xed_pkg::job_ctl_t                          head_ctl,
	output logic [xed_pkg::MAX_RES-1:0][CHAR_BITS-1:0] head_chars
);
	import xed_pkg::*;

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	job_ctl_t                          ctl_q   [QUEUE_DEPTH];
	logic [MAX_RES-1:0][CHAR_BITS-1:0] chars_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]               wr_ptr_q;
	logic [PTR_BITS-1:0]               rd_ptr_q;
	logic [CNT_BITS-1:0]               cnt_q;
	logic                              do_pop;

	assign q_ready    = cnt_q != CNT_BITS'(QUEUE_DEPTH);
	assign q_valid    = cnt_q != '0;
	assign do_pop     = pop && q_valid;
	assign head_ctl   = ctl_q[rd_ptr_q];
	assign head_chars = chars_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_BITS'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_BITS'(1);
			if (push && !do_pop)
				cnt_q <= cnt_q + CNT_BITS'(1);
			else if (do_pop && !push)
				cnt_q <= cnt_q - CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ctl_q[wr_ptr_q]   <= push_ctl;
			chars_q[wr_ptr_q] <= push_chars;
		end
	end

endmodule

// ===== rtl/core/xed_back.sv =====
// xed_back: takes jobs from the queue and sends their characters one per transaction
// depends on xed_pkg and xed_out_if
module xed_back #(
	parameter int CHAR_BITS = xed_pkg::CHAR_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       q_valid,
	output logic                                       pop,
	input  xed_pkg::job_ctl_t                          head_ctl,
	input  logic [xed_pkg::MAX_RES-1:0][CHAR_BITS-1:0] head_chars,
	xed_out_if.source                                  decoded
);
	import xed_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_RES);

	job_ctl_t                          job_ctl_q;
	logic [MAX_RES-1:0][CHAR_BITS-1:0] job_chars_q;
	logic [IDX_BITS-1:0]               idx_q;
	logic                              act_q;
	logic                              ovalid_q;
	logic [CHAR_BITS-1:0]              och_q;
	logic                              run_end_q;
	logic                              str_end_q;

	logic adv;
	logic last;
	logic emit;

	assign adv  = !ovalid_q || decoded.ready;
	assign last = COUNT_BITS'(idx_q) == job_ctl_q.count - COUNT_BITS'(1);
	assign emit = act_q && adv;
	assign pop  = q_valid && (!act_q || (emit && last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (emit)
				ovalid_q <= 1'b1;
			else if (adv)
				ovalid_q <= 1'b0;
			if (pop)
				act_q <= 1'b1;
			else if (emit && last)
				act_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			och_q     <= job_chars_q[idx_q];
			run_end_q <= last;
			str_end_q <= last && job_ctl_q.fin;
		end
		if (pop) begin
			job_ctl_q   <= head_ctl;
			job_chars_q <= head_chars;
			idx_q       <= '0;
		end else if (emit && !last) begin
			idx_q <= idx_q + IDX_BITS'(1);
		end
	end

	assign decoded.valid      = ovalid_q;
	assign decoded.out_ch     = och_q;
	assign decoded.run_end    = run_end_q;
	assign decoded.string_end = str_end_q;

endmodule

// ===== rtl/core/xml_entity_decoder.sv =====
// xml_entity_decoder: top level of the streaming xml character entity decoder
// depends on xed_pkg, xed_chan_if, xed_front, xed_queue and xed_back
//
// text carries one character per transaction (ch, is_final); decoded carries
// one output character per transaction with run_end on the last character
// caused by an input and string_end on the last character of the string.
// an ampersand and up to four following characters are held while they still
// spell the start of &lt; &gt; &amp; &quot; &apos; &#10; or &#13;; a full
// reference yields its single character, a broken match yields the held
// characters literally. held characters yield nothing until resolved.
// the front classifies one input per cycle, unless the queue is full, into
// a job of up to six characters and writes it into a two-entry job queue;
// while decoded does not stall, the back drains one character per cycle into
// the output register and plain text flows at one character per cycle. the
// first character of an input passes through a queue entry, the back's job
// register and the output register. when decoded stalls the output register
// holds, the queue fills and text ready drops once both entries are taken.
// reset empties the queue and output register and drops any held match.
module xml_entity_decoder #(
	parameter int CHAR_BITS = xed_pkg::CHAR_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	xed_in_if.sink    text,
	xed_out_if.source decoded
);
	import xed_pkg::*;

	logic                              q_ready;
	logic                              q_valid;
	logic                              push;
	logic                              pop;
	job_ctl_t                          push_ctl;
	job_ctl_t                          head_ctl;
	logic [MAX_RES-1:0][CHAR_BITS-1:0] push_chars;
	logic [MAX_RES-1:0][CHAR_BITS-1:0] head_chars;
	front_stat_t                       fstat;

	xed_front #(.CHAR_BITS(CHAR_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.q_ready    (q_ready),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_chars (push_chars),
		.stat       (fstat)
	);

	xed_queue #(.CHAR_BITS(CHAR_BITS)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ctl   (push_ctl),
		.push_chars (push_chars),
		.q_ready    (q_ready),
		.q_valid    (q_valid),
		.pop        (pop),
		.head_ctl   (head_ctl),
		.head_chars (head_chars)
	);

	xed_back #(.CHAR_BITS(CHAR_BITS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.pop        (pop),
		.head_ctl   (head_ctl),
		.head_chars (head_chars),
		.decoded    (decoded)
	);

	a_held_needs_amp: assert property (@(posedge clk) disable iff (!arst_n)
		fstat.held_cnt != '0 |-> fstat.pending)
		else $error("characters held without a pending ampersand");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.is_final |-> fstat.push)
		else $error("final character produced no job");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		text.valid && text.ready && text.is_final |=> !fstat.pending)
		else $error("match still pending after end of string");

	a_string_end_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		decoded.valid && decoded.string_end |-> decoded.run_end)
		else $error("string end without run end");

endmodule

// ===== verif/xed_decode_checker.sv =====
// xed_decode_checker: watches the text and decoded channels of the entity decoder,
// predicts each decoded character from the accepted text and compares in order
// depends on xed_pkg and the xed_in_if / xed_out_if interfaces
`timescale 1ns / 100ps

module xed_decode_checker #(
	parameter int CHAR_BITS = xed_pkg::CHAR_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	xed_in_if    text,
	xed_out_if   decoded,
	output int   fail_count,
	output int   due_count,
	output int   chars_in,
	output int   chars_out,
	output int   refs_hit
);

	typedef struct packed {
		logic [CHAR_BITS-1:0] ch;
		logic                 run_end;
		logic                 string_end;
	} out_char_t;

	localparam int N_ENT    = 7;
	localparam int MAX_HOLD = 4;
	localparam int MAX_SHOW = 10;

	localparam logic [CHAR_BITS-1:0] AMPERSAND = CHAR_BITS'(8'h26);

	localparam logic [7:0] ENT_NAME [N_ENT][5] = '{
		'{"l", "t", ";", 8'h00, 8'h00},
		'{"g", "t", ";", 8'h00, 8'h00},
		'{"a", "m", "p", ";", 8'h00},
		'{"q", "u", "o", "t", ";"},
		'{"a", "p", "o", "s", ";"},
		'{"#", "1", "0", ";", 8'h00},
		'{"#", "1", "3", ";", 8'h00}
	};
	localparam int ENT_LEN [N_ENT] = '{3, 3, 4, 5, 5, 4, 4};
	localparam logic [7:0] ENT_CHAR [N_ENT] = '{
		8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h0A, 8'h0D
	};

	logic                 amp_open;
	int                   held_n;
	logic [CHAR_BITS-1:0] held_q [MAX_HOLD];
	out_char_t            due_q [$];
	int                   bad = 0;
	int                   n_in = 0;
	int                   n_out = 0;
	int                   n_refs = 0;

	task automatic decode_text_char(input logic [CHAR_BITS-1:0] c, input logic fin);
		out_char_t burst [$];
		int        full;
		int        i;
		int        k;
		logic      part;
		logic      ok;
		full = -1;
		part = 1'b0;
		if (amp_open) begin
			for (i = 0; i < N_ENT; i++) begin
				ok = ENT_LEN[i] > held_n;
				for (k = 0; k < held_n; k++)
					if (held_q[k] != CHAR_BITS'(ENT_NAME[i][k]))
						ok = 1'b0;
				if (ok && CHAR_BITS'(ENT_NAME[i][held_n]) == c) begin
					if (ENT_LEN[i] == held_n + 1)
						full = i;
					else
						part = 1'b1;
				end
			end
			if (full >= 0) begin
				burst.insert(burst.size(), out_char_t'{CHAR_BITS'(ENT_CHAR[full]), 1'b0, 1'b0});
				amp_open = 1'b0;
				held_n = 0;
				n_refs++;
			end else if (part && !fin && held_n < MAX_HOLD) begin
				held_q[held_n] = c;
				held_n++;
			end else begin
				burst.insert(burst.size(), out_char_t'{AMPERSAND, 1'b0, 1'b0});
				for (k = 0; k < held_n; k++)
					burst.insert(burst.size(), out_char_t'{held_q[k], 1'b0, 1'b0});
				amp_open = 1'b0;
				held_n = 0;
				if (c == AMPERSAND && !fin)
					amp_open = 1'b1;
				else
					burst.insert(burst.size(), out_char_t'{c, 1'b0, 1'b0});
			end
		end else if (c == AMPERSAND && !fin) begin
			amp_open = 1'b1;
			held_n = 0;
		end else begin
			burst.insert(burst.size(), out_char_t'{c, 1'b0, 1'b0});
		end
		if (burst.size() > 0) begin
			burst[burst.size()-1].run_end = 1'b1;
			burst[burst.size()-1].string_end = fin;
		end
		foreach (burst[j])
			due_q.insert(due_q.size(), burst[j]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_char_t want;
		if (!arst_n) begin
			amp_open = 1'b0;
			held_n = 0;
			due_q.delete();
		end else begin
			if (text.valid && text.ready) begin
				n_in++;
				decode_text_char(text.ch, text.is_final);
			end
			if (decoded.valid && decoded.ready) begin
				n_out++;
				if (due_q.size() == 0) begin
					bad++;
					if (bad <= MAX_SHOW)
						$display("unexpected transaction: ch=%h run_end=%b string_end=%b",
							decoded.out_ch, decoded.run_end, decoded.string_end);
				end else begin
					want = due_q.pop_front();
					if (decoded.out_ch !== want.ch || decoded.run_end !== want.run_end ||
						decoded.string_end !== want.string_end) begin
						bad++;
						if (bad <= MAX_SHOW)
							$display("mismatch %0d: want ch=%h re=%b se=%b got ch=%h re=%b se=%b",
								n_out, want.ch, want.run_end, want.string_end,
								decoded.out_ch, decoded.run_end, decoded.string_end);
					end
				end
			end
		end
		fail_count <= bad;
		due_count  <= due_q.size();
		chars_in   <= n_in;
		chars_out  <= n_out;
		refs_hit   <= n_refs;
	end

endmodule

// ===== verif/xml_entity_decoder_tb.sv =====
// xml_entity_decoder_tb: drives text characters into the entity decoder with random
// idling on both channels and gives the verdict from the checker's failure and due counts
// depends on xed_pkg, xed_chan_if, xml_entity_decoder and xed_decode_checker
`timescale 1ns / 100ps

module xml_entity_decoder_tb;

	localparam int CHAR_BITS    = xed_pkg::CHAR_BITS_DEF;
	localparam int RANDOM_ITEMS = 75;
	localparam int CALM_ITEMS   = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 20;

	localparam logic [CHAR_BITS-1:0] AMPERSAND = CHAR_BITS'(8'h26);

	logic clk = 1'b0;
	logic arst_n;
	logic calm = 1'b0;
	int   cycles = 0;
	int   sent = 0;
	int   in_idle_pct = 0;
	int   fail_count;
	int   due_count;
	int   chars_in;
	int   chars_out;
	int   refs_hit;

	string ent_text [7] = '{"lt;", "gt;", "amp;", "quot;", "apos;", "#10;", "#13;"};

	xed_in_if  #(.CHAR_BITS(CHAR_BITS)) text_ch ();
	xed_out_if #(.CHAR_BITS(CHAR_BITS)) decoded_ch ();

	xml_entity_decoder #(.CHAR_BITS(CHAR_BITS)) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.text    (text_ch),
		.decoded (decoded_ch)
	);

	xed_decode_checker #(.CHAR_BITS(CHAR_BITS)) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.decoded    (decoded_ch),
		.fail_count (fail_count),
		.due_count  (due_count),
		.chars_in   (chars_in),
		.chars_out  (chars_out),
		.refs_hit   (refs_hit)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic send_char(input logic [CHAR_BITS-1:0] c, input logic fin);
		if (!calm && $urandom_range(1, 100) <= in_idle_pct) begin
			text_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		text_ch.valid    <= 1'b1;
		text_ch.ch       <= c;
		text_ch.is_final <= fin;
		@(posedge clk);
		while (!text_ch.ready) @(posedge clk);
		sent++;
	endtask

	task automatic send_string(input string s, input logic fin_last);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(CHAR_BITS'(s[i]), fin_last && i == s.len() - 1);
	endtask

	function automatic logic [CHAR_BITS-1:0] any_char();
		if ($urandom_range(0, 1))
			return CHAR_BITS'($urandom_range(0, (1 << CHAR_BITS) - 1));
		return CHAR_BITS'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic random_token();
		logic [CHAR_BITS-1:0] toks [$];
		int                   kind;
		int                   r;
		int                   plen;
		int                   j;
		logic                 fin;
		kind = $urandom_range(0, 9);
		r = $urandom_range(0, 6);
		fin = $urandom_range(0, 4) == 0;
		if (kind <= 3) begin
			toks.insert(toks.size(), AMPERSAND);
			for (j = 0; j < ent_text[r].len(); j++)
				toks.insert(toks.size(), CHAR_BITS'(ent_text[r][j]));
		end else if (kind <= 6) begin
			plen = $urandom_range(0, ent_text[r].len() - 1);
			toks.insert(toks.size(), AMPERSAND);
			for (j = 0; j < plen; j++)
				toks.insert(toks.size(), CHAR_BITS'(ent_text[r][j]));
			if (!(fin && $urandom_range(0, 1))) begin
				case ($urandom_range(0, 3))
					0: toks.insert(toks.size(), AMPERSAND);
					1: toks.insert(toks.size(), CHAR_BITS'($urandom_range(8'h20, 8'h7E)));
					2: toks.insert(toks.size(), any_char());
					default: toks.insert(toks.size(), CHAR_BITS'(ent_text[r][plen]) |
						(CHAR_BITS'(1) << $urandom_range(8, CHAR_BITS - 1)));
				endcase
			end
		end else begin
			for (j = $urandom_range(1, 4); j > 0; j--)
				toks.insert(toks.size(), any_char());
		end
		for (j = 0; j < toks.size(); j++)
			send_char(toks[j], fin && j == toks.size() - 1);
	endtask

	initial begin
		arst_n = 1'b0;
		text_ch.valid = 1'b0;
		text_ch.ch = '0;
		text_ch.is_final = 1'b0;
		decoded_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		send_char('0, 1'b0);
		send_char('1, 1'b0);
		send_string("&lt;", 1'b0);
		send_string("&quotX", 1'b0);
		send_string("&am&", 1'b0);
		send_string("#13;", 1'b0);
		send_string("&", 1'b1);
		send_string("&g", 1'b1);
		send_string("A", 1'b1);

		// random part
		while (sent < 25 + RANDOM_ITEMS) begin
			if (sent >= 25 + CALM_ITEMS)
				calm <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				in_idle_pct = 25 * $urandom_range(0, 2);
			random_token();
		end
		text_ch.valid <= 1'b0;

		@(posedge clk);
		while (due_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d text transactions and %0d decoded transactions",
			chars_in, chars_out);
		$display("%0d entity references resolved, %0d failures", refs_hit, fail_count);
		if (fail_count == 0 && due_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				decoded_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
			decoded_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

endmodule

// ===== xml_entity_decoder.f =====
rtl/core/xed_pkg.sv
rtl/core/xed_chan_if.sv
rtl/core/xed_front.sv
rtl/core/xed_queue.sv
rtl/core/xed_back.sv
rtl/core/xml_entity_decoder.sv
verif/xed_decode_checker.sv
verif/xml_entity_decoder_tb.sv
